FILE: hdl/rgb555_led_strip_serializer_defines.svh
// Assertion macros for the RGB555 LED strip serializer
`ifndef RGB555_LED_STRIP_SERIALIZER_DEFINES_SVH
`define RGB555_LED_STRIP_SERIALIZER_DEFINES_SVH

// Clocked assertion with an explicit clock and reset
`define RGBLS_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgbls assertion failed");

// Clocked assertion on the block clock and reset
`define RGBLS_ASSERT(lbl, prop) `RGBLS_ASSERT_CLK(lbl, clock, reset, prop)

`endif

FILE: hdl/rgbls_pkg.sv
// Types, constants and helpers shared by the RGB555 LED strip serializer
package rgbls_pkg;

   localparam int COLOR_W      = 5;
   localparam int PIXEL_W      = 3 * COLOR_W;
   localparam int LEVEL_W      = 8;
   localparam int INDEX_W      = 8;
   localparam int LED_COUNT_W  = 9;
   localparam int BIT_POS_W    = 5;
   localparam int HEADER_BITS  = 32;
   localparam int PIXEL_BITS   = 16;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_START = 2'd1,
      REQ_TICK  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PIXELS  = 2'd2,
      PH_TRAILER = 2'd3
   } phase_type;

   typedef struct packed {
      req_kind_type        kind;
      logic [INDEX_W-1:0]  pixel_index;
      logic [LEVEL_W-1:0]  red_level;
      logic [LEVEL_W-1:0]  green_level;
      logic [LEVEL_W-1:0]  blue_level;
   } item_type;

   typedef struct packed {
      logic clock_pulse;
      logic data_bit;
      logic busy_res;
      logic frame_done;
      logic idle;
   } result_type;

   // Serial word of one LED, bit i is sent i-th: start bit, blue, red, green, MSB first
   function automatic logic [PIXEL_BITS-1:0] pixel_word(input logic [PIXEL_W-1:0] pix);
      logic [PIXEL_BITS-1:0] w;
      w    = '0;
      w[0] = 1'b1;
      for (int i = 0; i < COLOR_W; i++) begin
         w[1 + i]  = pix[COLOR_W - 1 - i];
         w[6 + i]  = pix[3 * COLOR_W - 1 - i];
         w[11 + i] = pix[2 * COLOR_W - 1 - i];
      end
      return w;
   endfunction

endpackage

FILE: hdl/rgbls_pixel_mem.sv
// Pixel store with per-entry valid bits and same-cycle write bypass
module rgbls_pixel_mem
   import rgbls_pkg::*;
#(
   parameter int MAX_LEDS = 256,
   parameter int AW       = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PIXEL_W-1:0] wr_pixel,
   input  logic [AW-1:0]      rd_addr,
   output logic [PIXEL_W-1:0] rd_pixel
);

   logic [PIXEL_W-1:0]  store_ff [MAX_LEDS];
   logic [PIXEL_W-1:0]  rd_data_ff;
   logic [PIXEL_W-1:0]  byp_data_ff;
   logic [MAX_LEDS-1:0] valid_ff;
   logic                rd_ok_ff;
   logic                byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_pixel;
      end
      rd_data_ff  <= store_ff[rd_addr];
      byp_data_ff <= wr_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_ok_ff <= valid_ff[rd_addr];
         byp_ff   <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_pixel = byp_ff ? byp_data_ff : (rd_ok_ff ? rd_data_ff : '0);

endmodule

FILE: hdl/rgbls_sequencer.sv
// Frame sequencer: phase, LED and bit counters, serial bit selection
module rgbls_sequencer
   import rgbls_pkg::*;
#(
   parameter int MAX_LEDS = 256,
   parameter int AW       = 8,
   parameter int CW       = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  item_type               item,
   input  logic [LED_COUNT_W-1:0] led_count,
   input  logic [PIXEL_W-1:0]     rd_pixel,
   output logic [AW-1:0]          rd_addr,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [PIXEL_W-1:0]     wr_pixel,
   output result_type             result
);

   phase_type              phase_ff, phase_in;
   logic [CW-1:0]          led_ff, led_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [BIT_POS_W-1:0]   bit_ff, bit_in;
   logic [CW-1:0]          led_next;
   logic [PIXEL_BITS-1:0]  word;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         led_ff   <= '0;
         count_ff <= '0;
         bit_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         led_ff   <= led_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
      end
   end

   assign led_next = led_ff + CW'(1);
   assign word     = pixel_word(rd_pixel);
   assign wr_addr  = AW'(item.pixel_index);
   assign wr_pixel = {item.red_level[COLOR_W-1:0], item.green_level[COLOR_W-1:0],
                      item.blue_level[COLOR_W-1:0]};
   assign rd_addr  = AW'(led_in);

   always_comb begin
      phase_in           = phase_ff;
      led_in             = led_ff;
      count_in           = count_ff;
      bit_in             = bit_ff;
      wr_en              = 1'b0;
      result.clock_pulse = 1'b0;
      result.data_bit    = 1'b0;
      result.frame_done  = 1'b0;
      if (advance) begin
         case (item.kind)
            REQ_WRITE: begin
               wr_en = (32'(item.pixel_index) < MAX_LEDS);
            end
            REQ_START: begin
               if (phase_ff == PH_IDLE) begin
                  count_in = (32'(led_count) > MAX_LEDS) ? CW'(MAX_LEDS) : CW'(led_count);
                  phase_in = PH_HEADER;
                  led_in   = '0;
                  bit_in   = '0;
               end
            end
            REQ_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  result.clock_pulse = 1'b1;
                  case (phase_ff)
                     PH_HEADER: begin
                        if (bit_ff == BIT_POS_W'(HEADER_BITS - 1)) begin
                           bit_in = '0;
                           led_in = '0;
                           if (count_ff == '0) begin
                              phase_in          = PH_IDLE;
                              result.frame_done = 1'b1;
                           end else begin
                              phase_in = PH_PIXELS;
                           end
                        end else begin
                           bit_in = bit_ff + BIT_POS_W'(1);
                        end
                     end
                     PH_PIXELS: begin
                        result.data_bit = word[bit_ff[3:0]];
                        if (bit_ff[3:0] == 4'(PIXEL_BITS - 1)) begin
                           bit_in = '0;
                           if (led_next >= count_ff) begin
                              led_in   = '0;
                              phase_in = PH_TRAILER;
                           end else begin
                              led_in = led_next;
                           end
                        end else begin
                           bit_in = bit_ff + BIT_POS_W'(1);
                        end
                     end
                     default: begin
                        if (led_next >= count_ff) begin
                           led_in            = '0;
                           phase_in          = PH_IDLE;
                           result.frame_done = 1'b1;
                        end else begin
                           led_in = led_next;
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
      result.busy_res = (phase_in != PH_IDLE);
      result.idle     = (phase_ff == PH_IDLE);
   end

endmodule

FILE: hdl/rgb555_led_strip_serializer.sv
// Top level of the RGB555 LED strip serializer: stream ports, input and result registers
// Takes one request transaction per clock unless the result stream stalls, and returns
// one registered result transaction for each; a tick may come every clock, so the serial
// bit rate is set by the tick source. The pixel store is a memory with one write and one
// registered read port, read ahead at the LED position the next tick will use; reset
// clears it at once through per-entry valid bits, so no clearing pass is needed.
`include "rgb555_led_strip_serializer_defines.svh"

module rgb555_led_strip_serializer
   import rgbls_pkg::*;
#(
   parameter int MAX_LEDS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // pixel_index, red_level, green_level, blue_level
   input  logic [1:0]             req_tuser,   // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // clock_pulse, data_bit, busy_res, zero pad
   output logic                   rsp_tlast,   // frame_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LED_COUNT_W-1:0] csr_data     // led_count
);

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CW = $clog2(MAX_LEDS + 1);

   logic                   req_valid_ff, req_valid_in;
   item_type               item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_res_ff;
   logic [LED_COUNT_W-1:0] led_count_ff;
   logic                   advance;
   logic                   accept;
   result_type             result;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [PIXEL_W-1:0]     wr_pixel;
   logic [PIXEL_W-1:0]     rd_pixel;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         led_count_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            led_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind        <= req_kind_type'(req_tuser);
         item_ff.pixel_index <= req_tdata[7:0];
         item_ff.red_level   <= req_tdata[15:8];
         item_ff.green_level <= req_tdata[23:16];
         item_ff.blue_level  <= req_tdata[31:24];
      end
      if (advance) begin
         rsp_res_ff <= result;
      end
   end

   rgbls_sequencer #(
      .MAX_LEDS (MAX_LEDS),
      .AW       (AW),
      .CW       (CW)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .led_count (led_count_ff),
      .rd_pixel  (rd_pixel),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_pixel  (wr_pixel),
      .result    (result)
   );

   rgbls_pixel_mem #(
      .MAX_LEDS (MAX_LEDS),
      .AW       (AW)
   ) u_pixel_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_pixel (wr_pixel),
      .rd_addr  (rd_addr),
      .rd_pixel (rd_pixel)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_res_ff.busy_res, rsp_res_ff.data_bit,
                        rsp_res_ff.clock_pulse};
   assign rsp_tlast  = rsp_res_ff.frame_done;

   `RGBLS_ASSERT(a_done_ends_frame,
      rsp_valid_ff && rsp_res_ff.frame_done |-> rsp_res_ff.clock_pulse && !rsp_res_ff.busy_res)
   `RGBLS_ASSERT(a_data_needs_pulse,
      rsp_valid_ff && rsp_res_ff.data_bit |-> rsp_res_ff.clock_pulse)
   `RGBLS_ASSERT(a_idle_tick_silent,
      advance && item_ff.kind == REQ_TICK && result.idle |=> !rsp_res_ff.clock_pulse)

endmodule
